// ===== hdl/hs_pkg.sv =====
// shared types and constants of the heap sorter
`default_nettype none

package hs_pkg;

  // width of one stored value
  localparam int DATA_W = 32;

  // default number of store entries
  localparam int CAPACITY_DEF = 64;

  // sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BUILD,
    ST_ROOT,
    ST_SIFT_L,
    ST_SIFT_R,
    ST_SIFT_C,
    ST_SIFT_D,
    ST_EXTR,
    ST_EXTR_A,
    ST_EXTR_B,
    ST_OUT_RD,
    ST_OUT_WT
  } st_t;

endpackage : hs_pkg

`default_nettype wire

// ===== hdl/heap_sorter_unit.sv =====
// heap sorter top level: load, heapify, extract and stream out a batch
//
// usage:
//   in_* takes one signed 32-bit value per request; in_tlast marks the last
//   value of a batch and starts the sort. in_tready is high only while the
//   block loads. Values past CAPACITY are dropped and the whole batch then
//   comes out with out_tuser set.
//   out_* returns the batch in ascending order, out_tlast on the largest.
//   timing: loading takes one value per cycle. Sorting runs on the single
//   read port of the value store: each sift level steps through reading the
//   left child, reading the right child when present, comparing and writing
//   back, plus the build and root states per heapify root and the extract
//   states per extraction; each result then passes through an address state
//   and a registered read into the output register.
//   The next batch is taken as soon as the last result sits in the output
//   register, even while the receiver still stalls on it; a stall only
//   holds the sequencer in its output wait state.
//   reset: sync, active low; fill count and overflow mark clear, the store
//   contents are left as they are and are always written before being read.
`default_nettype none

module heap_sorter_unit #(
  parameter int CAPACITY = hs_pkg::CAPACITY_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // input channel
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [hs_pkg::DATA_W-1:0] in_tdata,  // [31:0] sample
  input  wire logic                      in_tlast,  // final_item
  // result channel
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic      [hs_pkg::DATA_W-1:0] out_tdata, // [31:0] sorted_value
  output logic                           out_tlast, // end_of_run
  output logic                           out_tuser  // [0] overflowed
);
  import hs_pkg::*;

  localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CW   = IDXW + 2;
  localparam logic [CNTW-1:0] CAP_C = CNTW'(CAPACITY);

  // sequencer and counters
  st_t             state_r, state_nxt;
  logic [CNTW-1:0] fill_r, fill_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CNTW-1:0] n_r, n_nxt;
  logic [CNTW-1:0] heap_len_r, heap_len_nxt;
  logic [CNTW-1:0] k_r, k_nxt;
  logic [CNTW-1:0] out_idx_r, out_idx_nxt;
  logic            build_r, build_nxt;
  logic [IDXW-1:0] pos_r, pos_nxt;

  // datapath registers
  logic [DATA_W-1:0] cur_val_r, cur_val_nxt;
  logic [DATA_W-1:0] best_val_r, best_val_nxt;
  logic [IDXW-1:0]   best_idx_r, best_idx_nxt;
  logic              best_child_r, best_child_nxt;
  logic [DATA_W-1:0] root_val_r, root_val_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  // store ports
  logic              mem_we;
  logic [IDXW-1:0]   mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic [IDXW-1:0]   mem_ra;
  logic [DATA_W-1:0] mem_rd;

  logic            in_acc;
  logic            fill_room;
  logic [CW-1:0]   lc_idx, rc_idx;
  logic            lc_in, rc_in;
  logic            out_free;
  logic            out_load;
  logic            out_final;
  logic            sift_done;
  logic [CNTW-1:0] fill_inc;

  hs_ram #(
    .DEPTH (CAPACITY),
    .AW    (IDXW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_addr (mem_ra),
    .rd_data (mem_rd)
  );

  // common decodes
  assign in_acc    = in_tvalid && in_tready;
  assign fill_room = (fill_r < CAP_C);
  assign fill_inc  = fill_r + CNTW'(1);
  assign lc_idx    = CW'({pos_r, 1'b1});
  assign rc_idx    = lc_idx + CW'(1);
  assign lc_in     = (lc_idx < CW'(heap_len_r));
  assign rc_in     = (rc_idx < CW'(heap_len_r));
  assign out_free  = !out_valid_r || out_tready;
  assign out_final = ((out_idx_r + CNTW'(1)) == n_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc && in_tlast) state_nxt = ST_BUILD;
      end
      ST_BUILD: begin
        if (k_r == '0) state_nxt = ST_EXTR;
        else           state_nxt = ST_ROOT;
      end
      ST_ROOT:   state_nxt = ST_SIFT_L;
      ST_SIFT_L: begin
        if (!lc_in) state_nxt = build_r ? ST_BUILD : ST_EXTR;
        else        state_nxt = ST_SIFT_R;
      end
      ST_SIFT_R: begin
        if (rc_in) state_nxt = ST_SIFT_C;
        else       state_nxt = ST_SIFT_D;
      end
      ST_SIFT_C: state_nxt = ST_SIFT_D;
      ST_SIFT_D: begin
        if (!best_child_r) state_nxt = build_r ? ST_BUILD : ST_EXTR;
        else               state_nxt = ST_SIFT_L;
      end
      ST_EXTR: begin
        if (heap_len_r <= CNTW'(1)) state_nxt = ST_OUT_RD;
        else                        state_nxt = ST_EXTR_A;
      end
      ST_EXTR_A: state_nxt = ST_EXTR_B;
      ST_EXTR_B: state_nxt = ST_SIFT_L;
      ST_OUT_RD: state_nxt = ST_OUT_WT;
      ST_OUT_WT: begin
        if (out_free) state_nxt = out_final ? ST_LOAD : ST_OUT_RD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // store access and handshake outputs
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_wa    = pos_r;
    mem_wd    = cur_val_r;
    mem_ra    = pos_r;
    out_load  = 1'b0;
    sift_done = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        mem_we    = in_acc && fill_room;
        mem_wa    = fill_r[IDXW-1:0];
        mem_wd    = in_tdata;
      end
      ST_BUILD: begin
        mem_ra = IDXW'(k_r - CNTW'(1));
      end
      ST_SIFT_L: begin
        mem_ra = lc_idx[IDXW-1:0];
        if (!lc_in) begin
          mem_we    = 1'b1;
          sift_done = 1'b1;
        end
      end
      ST_SIFT_R: begin
        mem_ra = rc_idx[IDXW-1:0];
      end
      ST_SIFT_D: begin
        mem_we    = 1'b1;
        sift_done = !best_child_r;
        if (best_child_r) mem_wd = best_val_r;
      end
      ST_EXTR: begin
        mem_ra = '0;
      end
      ST_EXTR_A: begin
        mem_ra = IDXW'(heap_len_r - CNTW'(1));
      end
      ST_EXTR_B: begin
        mem_we = 1'b1;
        mem_wa = IDXW'(heap_len_r - CNTW'(1));
        mem_wd = root_val_r;
      end
      ST_OUT_RD, ST_OUT_WT: begin
        mem_ra   = out_idx_r[IDXW-1:0];
        out_load = (state_r == ST_OUT_WT) && out_free;
      end
      default: begin
        mem_ra = pos_r;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    fill_nxt       = fill_r;
    ovf_nxt        = ovf_r;
    n_nxt          = n_r;
    heap_len_nxt   = heap_len_r;
    k_nxt          = k_r;
    out_idx_nxt    = out_idx_r;
    build_nxt      = build_r;
    pos_nxt        = pos_r;
    cur_val_nxt    = cur_val_r;
    best_val_nxt   = best_val_r;
    best_idx_nxt   = best_idx_r;
    best_child_nxt = best_child_r;
    root_val_nxt   = root_val_r;

    // sift finished: step the heapify root or go to the next extraction
    if (sift_done && build_r) k_nxt = k_r - CNTW'(1);

    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (fill_room) fill_nxt = fill_inc;
          else           ovf_nxt  = 1'b1;
          if (in_tlast) begin
            n_nxt        = fill_room ? fill_inc : fill_r;
            heap_len_nxt = n_nxt;
            k_nxt        = n_nxt >> 1;
            build_nxt    = 1'b1;
          end
        end
      end
      ST_BUILD: begin
        if (k_r == '0) begin
          build_nxt = 1'b0;
        end else begin
          pos_nxt = IDXW'(k_r - CNTW'(1));
        end
      end
      ST_ROOT: begin
        cur_val_nxt = mem_rd;
      end
      ST_SIFT_R: begin
        // left child against the value being sifted
        if ($signed(mem_rd) > $signed(cur_val_r)) begin
          best_val_nxt   = mem_rd;
          best_idx_nxt   = lc_idx[IDXW-1:0];
          best_child_nxt = 1'b1;
        end else begin
          best_val_nxt   = cur_val_r;
          best_idx_nxt   = pos_r;
          best_child_nxt = 1'b0;
        end
      end
      ST_SIFT_C: begin
        // right child against the best so far
        if ($signed(mem_rd) > $signed(best_val_r)) begin
          best_val_nxt   = mem_rd;
          best_idx_nxt   = rc_idx[IDXW-1:0];
          best_child_nxt = 1'b1;
        end
      end
      ST_SIFT_D: begin
        if (best_child_r) pos_nxt = best_idx_r;
      end
      ST_EXTR: begin
        if (heap_len_r <= CNTW'(1)) out_idx_nxt = '0;
      end
      ST_EXTR_A: begin
        root_val_nxt = mem_rd;
      end
      ST_EXTR_B: begin
        cur_val_nxt  = mem_rd;
        heap_len_nxt = heap_len_r - CNTW'(1);
        pos_nxt      = '0;
      end
      ST_OUT_WT: begin
        if (out_free) begin
          if (out_final) begin
            fill_nxt = '0;
            ovf_nxt  = 1'b0;
          end else begin
            out_idx_nxt = out_idx_r + CNTW'(1);
          end
        end
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = mem_rd;
      out_last_nxt  = out_final;
      out_ovf_nxt   = ovf_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      build_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      build_r     <= build_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    heap_len_r   <= heap_len_nxt;
    k_r          <= k_nxt;
    out_idx_r    <= out_idx_nxt;
    pos_r        <= pos_nxt;
    cur_val_r    <= cur_val_nxt;
    best_val_r   <= best_val_nxt;
    best_idx_r   <= best_idx_nxt;
    best_child_r <= best_child_nxt;
    root_val_r   <= root_val_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

  // fill count never passes the store size
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CAP_C)
    else $error("fill count beyond capacity");

  // a result never overwrites one the receiver has not taken
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("output register overwritten");

  // the sift position always lies inside the live heap
  a_pos_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIFT_L || state_r == ST_SIFT_D) |-> (CNTW'(pos_r) < heap_len_r))
    else $error("sift position outside heap");

  // the last result of a batch hands the block back to loading
  a_last_reloads: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_final) |=> (state_r == ST_LOAD && fill_r == '0 && !ovf_r))
    else $error("batch end did not return to loading");

endmodule : heap_sorter_unit

`default_nettype wire

// ===== hdl/hs_ram.sv =====
// value store: one write port, one registered read port
`default_nettype none

module hs_ram #(
  parameter int DEPTH = hs_pkg::CAPACITY_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [hs_pkg::DATA_W-1:0] wr_data,
  input  wire logic [AW-1:0]             rd_addr,
  output logic      [hs_pkg::DATA_W-1:0] rd_data
);
  import hs_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : hs_ram

`default_nettype wire

// ===== sim/heap_sorter_unit_test.sv =====
// self-checking bench for heap_sorter_unit: scripted and random batches against a heap sort predictor
module heap_sorter_unit_test;

  localparam int CAP         = hs_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int SCRIPT_LEN  = 18;
  localparam int IDLE_PCT    = 16;
  localparam int HOLD_CYCLES = 1500;
  localparam int PRINT_MAX   = 50;

  typedef logic signed [hs_pkg::DATA_W-1:0] word_t;

  // one scripted request; want is used only when typed is set
  typedef struct packed {
    logic [hs_pkg::DATA_W-1:0] sample;
    logic                      last;
    logic                      typed;
    logic [hs_pkg::DATA_W-1:0] want;
  } script_row_t;

  // one expected result
  typedef struct {
    word_t value;
    logic  last;
    logic  ovf;
  } sorted_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [hs_pkg::DATA_W-1:0] in_tdata = '0;  // [31:0] sample
  logic in_tlast = 1'b0;                     // final_item
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [hs_pkg::DATA_W-1:0] out_tdata;      // [31:0] sorted_value
  logic out_tlast;                           // end_of_run
  logic out_tuser;                           // [0] overflowed

  // predictor state: the batch being collected
  word_t batch_buf [CAP];
  int    batch_fill = 0;
  logic  batch_ovf = 1'b0;
  sorted_t due_q [$];

  int  err_count = 0;
  int  results_seen = 0;
  int  items_taken = 0;
  int  cycle = 0;
  bit  calm = 1'b0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  // single-value batches have obvious answers, the rest go through the predictor
  script_row_t script [SCRIPT_LEN] = '{
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFB, 1'b1, 1'b0, 32'h0},
    '{32'h1234_5678, 1'b0, 1'b0, 32'h0},
    '{32'h1234_5678, 1'b0, 1'b0, 32'h0},
    '{32'h1234_5678, 1'b1, 1'b0, 32'h0},
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b1, 1'b0, 32'h0}
  };

  heap_sorter_unit #(.CAPACITY(CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // clock
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= PRINT_MAX) begin
      $display("mismatch at cycle %0d: %s", cycle, what);
    end
  endtask

  // move entry root down until no child is larger, within len entries
  task automatic sift_down(input int len, input int root);
    int    pos;
    int    top;
    int    lc;
    word_t t;
    pos = root;
    forever begin
      top = pos;
      lc = 2 * pos + 1;
      if (lc < len && batch_buf[lc] > batch_buf[top]) top = lc;
      if (lc + 1 < len && batch_buf[lc + 1] > batch_buf[top]) top = lc + 1;
      if (top == pos) break;
      t = batch_buf[pos];
      batch_buf[pos] = batch_buf[top];
      batch_buf[top] = t;
      pos = top;
    end
  endtask

  // heapify then extract: ascending order in place
  task automatic heap_sort(input int len);
    word_t t;
    for (int k = len / 2; k > 0; k--) sift_down(len, k - 1);
    for (int k = len; k > 1; k--) begin
      t = batch_buf[0];
      batch_buf[0] = batch_buf[k - 1];
      batch_buf[k - 1] = t;
      sift_down(k - 1, 0);
    end
  endtask

  // store or drop one value; a closing value sorts and queues the batch
  task automatic absorb_sample(input word_t v, input logic last);
    if (batch_fill < CAP) begin
      batch_buf[batch_fill] = v;
      batch_fill++;
    end else begin
      batch_ovf = 1'b1;
    end
    if (last) begin
      heap_sort(batch_fill);
      for (int k = 0; k < batch_fill; k++) begin
        due_q.push_back('{batch_buf[k], k == batch_fill - 1, batch_ovf});
      end
      batch_fill = 0;
      batch_ovf = 1'b0;
    end
  endtask

  // offer one request, wait for it to be taken, then update the prediction
  task automatic send_sample(input word_t v, input logic last, input logic typed,
                             input word_t want);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    items_taken++;
    calm = (items_taken >= 60 && items_taken < 130);
    if (typed) begin
      due_q.push_back('{want, 1'b1, 1'b0});
      batch_fill = 0;
      batch_ovf = 1'b0;
    end else begin
      absorb_sample(v, last);
    end
    @(negedge clk);
  endtask

  // random values with extremes and narrow ranges for duplicates
  function automatic word_t pick_sample();
    case ($urandom_range(3))
      0: return word_t'($urandom_range(31)) - 16;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return word_t'($urandom);
    endcase
  endfunction

  // receiver: random stalls, one long hold-off, a calm stretch
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (!hold_done && results_seen >= 40) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // result checker
  always @(posedge clk) begin
    sorted_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (due_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_tdata));
      end else begin
        e = due_q.pop_front();
        if (out_tdata !== e.value)
          report_mismatch($sformatf("sorted_value %h, want %h", out_tdata, e.value));
        if (out_tlast !== e.last)
          report_mismatch($sformatf("end_of_run %b, want %b", out_tlast, e.last));
        if (out_tuser !== e.ovf)
          report_mismatch($sformatf("overflowed %b, want %b", out_tuser, e.ovf));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle++;
    if (cycle == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // main sequence
  initial begin
    int batch_no;
    int rand_items;
    int size;
    batch_no = 0;
    rand_items = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // scripted batches
    for (int r = 0; r < SCRIPT_LEN; r++) begin
      send_sample(script[r].sample, script[r].last, script[r].typed, script[r].want);
    end

    // random batches: mostly small, batch 2 exactly full, batch 5 past capacity
    while (rand_items < 150 || batch_no < 6) begin
      if (batch_no == 2) size = CAP;
      else if (batch_no == 5) size = CAP + 2;
      else if ($urandom_range(15) == 0) size = $urandom_range(CAP + 6, CAP - 2);
      else size = $urandom_range(12, 1);
      for (int i = 0; i < size; i++) begin
        send_sample(pick_sample(), i == size - 1, 1'b0, '0);
      end
      rand_items += size;
      batch_no++;
    end
    in_tvalid <= 1'b0;

    // drain
    while (due_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
